// ===== rtl/lsra_pkg.sv =====
// Shared types and constants for the linear scan register assigner.
`default_nettype none

package lsra_pkg;

    // Register file and field sizing
    localparam int NUM_REGS   = 7;
    localparam int NUM_CALLEE = 5;
    localparam int POS_BITS   = 16;
    localparam int INDEX_BITS = 16;
    localparam int REG_BITS   = 3;
    localparam int SLOT_BITS  = $clog2(NUM_REGS);
    localparam int CNT_BITS   = $clog2(NUM_REGS + 1);

    // Register code that marks a spilled interval
    localparam logic [REG_BITS-1:0] SPILL_CODE = REG_BITS'(NUM_REGS);

    // Registers below NUM_CALLEE are callee-saved
    localparam logic [NUM_REGS-1:0] CALLEE_MASK = NUM_REGS'((1 << NUM_CALLEE) - 1);

    typedef struct packed {
        logic [POS_BITS-1:0] start_pos;
        logic [POS_BITS-1:0] end_pos;
        logic                last_interval;
    } lsra_in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] interval_index;
        logic [REG_BITS-1:0]   assigned_reg;
        logic                  victim_valid;
        logic [INDEX_BITS-1:0] victim_index;
        logic                  callee_saved_used;
    } lsra_out_t;

endpackage

`default_nettype wire

// ===== rtl/linear_scan_register_assigner.sv =====
// Linear scan register assigner: sequencer, active list and free-register stack.
// Usage: live intervals enter on the item channel (item_valid / item_stall /
// item), sorted by start position. Each item yields exactly one result on the
// result channel (result_valid / result_stall / result): the interval's
// sequence number, its register or the spill code, an optional victim whose
// register was taken, and a flag for callee-saved register use so far.
// One item is worked at a time. A single compare unit walks the active list:
// the retire pass reads one entry per cycle and, after each retired entry,
// moves the last entry into the retired slot before rechecking it; when no
// register is free, a victim search walks the list once more, one entry per
// cycle. After acceptance an item passes the retire pass, the allocation
// state, the victim search if needed and the final state, which loads the
// output register; item_stall is high while one is in work. A finished
// result sits in an output register, so the next item is accepted while it
// waits; a stalled result holds until taken, and the sequencer waits in its
// final state only if a second result is ready.
// Reset (rst_n low) empties the active list, refills the free stack with
// register 0 on top, and clears use flags and the sequence counter. An item
// with last_interval set restores that same state after its result.
`default_nettype none

module linear_scan_register_assigner (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  lsra_pkg::lsra_in_t     item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output lsra_pkg::lsra_out_t    result
);

    import lsra_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_CHK,
        ST_EXP_MOVE,
        ST_ALLOC,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] seq;
        logic [POS_BITS-1:0]   end_p;
        logic [REG_BITS-1:0]   phys;
    } act_t;

    state_t                state_reg;
    act_t                  act_list_reg [NUM_REGS];
    logic [REG_BITS-1:0]   free_stack_reg [NUM_REGS];
    logic [CNT_BITS-1:0]   act_count_reg;
    logic [CNT_BITS-1:0]   free_count_reg;
    logic [NUM_REGS-1:0]   used_reg;
    logic [INDEX_BITS-1:0] item_count_reg;
    logic [CNT_BITS-1:0]   scan_reg;
    logic [POS_BITS-1:0]   start_reg;
    logic [POS_BITS-1:0]   end_reg;
    logic                  last_reg;
    logic [INDEX_BITS-1:0] seq_reg;
    logic [REG_BITS-1:0]   asg_reg;
    logic                  vvalid_reg;
    logic [INDEX_BITS-1:0] vidx_reg;
    logic [POS_BITS-1:0]   latest_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic                  found_reg;
    logic [INDEX_BITS-1:0] cand_seq_reg;
    logic [REG_BITS-1:0]   cand_phys_reg;
    logic                  out_valid_reg;
    lsra_out_t             out_item_reg;

    logic [SLOT_BITS-1:0]  rd_idx;
    act_t                  rd_ent;
    logic                  scan_live;
    logic [CNT_BITS-1:0]   fc_m1;
    logic [REG_BITS-1:0]   pop_phys;
    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_idx;
    act_t                  wr_ent;
    logic                  accept;
    logic                  out_free;
    logic [POS_BITS-1:0]   cmp_a;
    logic [POS_BITS-1:0]   cmp_b;
    logic                  cmp_gt;

    // Handshake
    assign accept       = item_valid && (state_reg == ST_IDLE);
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    // Single read port of the active list
    assign rd_idx    = (state_reg == ST_EXP_MOVE) ? act_count_reg[SLOT_BITS-1:0]
                                                  : scan_reg[SLOT_BITS-1:0];
    assign rd_ent    = act_list_reg[rd_idx];
    assign scan_live = (scan_reg < act_count_reg);

    // Shared compare unit: start past end while retiring, end past latest while searching
    assign cmp_a  = (state_reg == ST_SEARCH) ? rd_ent.end_p : start_reg;
    assign cmp_b  = (state_reg == ST_SEARCH) ? latest_reg : rd_ent.end_p;
    assign cmp_gt = (cmp_a > cmp_b);

    // Top of the free stack
    assign fc_m1    = free_count_reg - CNT_BITS'(1);
    assign pop_phys = free_stack_reg[fc_m1[SLOT_BITS-1:0]];

    // Single write port of the active list
    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = scan_reg[SLOT_BITS-1:0];
        wr_ent = rd_ent;
        case (state_reg)
            ST_EXP_MOVE:
            begin
                wr_en = 1'b1;
            end
            ST_ALLOC:
            begin
                wr_idx = act_count_reg[SLOT_BITS-1:0];
                wr_ent = '{seq: seq_reg, end_p: end_reg, phys: pop_phys};
                wr_en  = (free_count_reg != '0) && (act_count_reg < CNT_BITS'(NUM_REGS));
            end
            ST_SEARCH:
            begin
                wr_idx = slot_reg;
                wr_ent = '{seq: seq_reg, end_p: end_reg, phys: cand_phys_reg};
                wr_en  = !scan_live && found_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Active list storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            act_list_reg[wr_idx] <= wr_ent;
        end
    end

    // Sequencer, bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            act_count_reg  <= '0;
            free_count_reg <= CNT_BITS'(NUM_REGS);
            for (int k = 0; k < NUM_REGS; k++)
            begin
                free_stack_reg[k] <= REG_BITS'(NUM_REGS - 1 - k);
            end
            used_reg       <= '0;
            item_count_reg <= '0;
            scan_reg       <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            last_reg       <= 1'b0;
            seq_reg        <= '0;
            asg_reg        <= SPILL_CODE;
            vvalid_reg     <= 1'b0;
            vidx_reg       <= '0;
            latest_reg     <= '0;
            slot_reg       <= '0;
            found_reg      <= 1'b0;
            cand_seq_reg   <= '0;
            cand_phys_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            // Drop a result once taken
            if (out_valid_reg && !result_stall && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        start_reg  <= item.start_pos;
                        end_reg    <= item.end_pos;
                        last_reg   <= item.last_interval;
                        seq_reg    <= item_count_reg;
                        if (item_count_reg != '1)
                        begin
                            item_count_reg <= item_count_reg + INDEX_BITS'(1);
                        end
                        scan_reg   <= '0;
                        asg_reg    <= SPILL_CODE;
                        vvalid_reg <= 1'b0;
                        vidx_reg   <= '0;
                        state_reg  <= ST_EXP_CHK;
                    end
                end

                // Retire entries that ended before the new start
                ST_EXP_CHK:
                begin
                    if (!scan_live)
                    begin
                        state_reg <= ST_ALLOC;
                    end
                    else if (cmp_gt)
                    begin
                        if (free_count_reg < CNT_BITS'(NUM_REGS))
                        begin
                            free_stack_reg[free_count_reg[SLOT_BITS-1:0]] <= rd_ent.phys;
                            free_count_reg <= free_count_reg + CNT_BITS'(1);
                        end
                        act_count_reg <= act_count_reg - CNT_BITS'(1);
                        state_reg     <= ST_EXP_MOVE;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + CNT_BITS'(1);
                    end
                end

                // Last entry moves into the retired slot; recheck that slot
                ST_EXP_MOVE:
                begin
                    state_reg <= ST_EXP_CHK;
                end

                // Pop a free register, or start the victim search
                ST_ALLOC:
                begin
                    if (free_count_reg != '0)
                    begin
                        free_count_reg     <= fc_m1;
                        asg_reg            <= pop_phys;
                        used_reg[pop_phys] <= 1'b1;
                        if (act_count_reg < CNT_BITS'(NUM_REGS))
                        begin
                            act_count_reg <= act_count_reg + CNT_BITS'(1);
                        end
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        scan_reg   <= '0;
                        latest_reg <= end_reg;
                        found_reg  <= 1'b0;
                        slot_reg   <= '0;
                        state_reg  <= ST_SEARCH;
                    end
                end

                // Find the first entry with the strictly latest end past the new interval's end
                ST_SEARCH:
                begin
                    if (scan_live)
                    begin
                        if (cmp_gt)
                        begin
                            latest_reg    <= rd_ent.end_p;
                            slot_reg      <= scan_reg[SLOT_BITS-1:0];
                            found_reg     <= 1'b1;
                            cand_seq_reg  <= rd_ent.seq;
                            cand_phys_reg <= rd_ent.phys;
                        end
                        scan_reg <= scan_reg + CNT_BITS'(1);
                    end
                    else
                    begin
                        if (found_reg)
                        begin
                            asg_reg    <= cand_phys_reg;
                            vvalid_reg <= 1'b1;
                            vidx_reg   <= cand_seq_reg;
                        end
                        state_reg <= ST_DONE;
                    end
                end

                // Hand the result to the output register
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                  <= 1'b1;
                        out_item_reg.interval_index    <= seq_reg;
                        out_item_reg.assigned_reg      <= asg_reg;
                        out_item_reg.victim_valid      <= vvalid_reg;
                        out_item_reg.victim_index      <= vidx_reg;
                        out_item_reg.callee_saved_used <= |(used_reg & CALLEE_MASK);
                        if (last_reg)
                        begin
                            act_count_reg  <= '0;
                            free_count_reg <= CNT_BITS'(NUM_REGS);
                            for (int k = 0; k < NUM_REGS; k++)
                            begin
                                free_stack_reg[k] <= REG_BITS'(NUM_REGS - 1 - k);
                            end
                            used_reg       <= '0;
                            item_count_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
